/* sv/zdsm_pkg.sv */
// Shared constants and control types for the zoned disk sector mapper.
`timescale 1ns / 1ps
package zdsm_pkg;

   localparam int TRACKS    = 80;
   localparam int TRK_W     = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam logic [TRK_W-1:0] LAST_TRK = TRK_W'(TRACKS - 1);

   localparam int TIX_W     = 7;
   localparam int CNT_W     = 5;
   localparam int BLK_W     = 12;
   localparam int TRK_OUT_W = 7;
   localparam int SEC_W     = 5;

   localparam int SUM_W     = BLK_W + 1;
   localparam int DQ_W      = BLK_W + 2;
   localparam int REM_W     = CNT_W + 1;
   localparam int DIV_STEPS = DQ_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MAP  = 1'b1;

   typedef struct packed {
      logic             start_map;
      logic             start_load;
      logic             walk_step;
      logic             walk_stop;
      logic             div_step;
      logic             div_next;
      logic             finish;
      logic [TRK_W-1:0] idx;
   } zdsm_cmd_type;

   typedef struct packed {
      logic hit;
      logic out_free;
   } zdsm_sts_type;

endpackage

/* sv/zdsm_req_if.sv */
// Request channel interface: valid/ready handshake and the request payload.
`timescale 1ns / 1ps
interface zdsm_req_if
   import zdsm_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [TIX_W-1:0] track_index;
   logic [CNT_W-1:0] sectors_in_track;
   logic [BLK_W-1:0] block_number;

   modport source (output valid, cmd, track_index, sectors_in_track, block_number,
                   input ready);
   modport sink   (input valid, cmd, track_index, sectors_in_track, block_number,
                   output ready);
endinterface

/* sv/zdsm_rsp_if.sv */
// Response channel interface: valid/ready handshake and the mapped location.
`timescale 1ns / 1ps
interface zdsm_rsp_if
   import zdsm_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [TRK_OUT_W-1:0] track;
   logic [SEC_W-1:0]     sector;
   logic                 beyond_end;

   modport source (output valid, track, sector, beyond_end, input ready);
   modport sink   (input valid, track, sector, beyond_end, output ready);
endinterface

/* sv/zoned_disk_sector_mapper_core.sv */
// Top level of the zoned disk sector mapper: controller, datapath, channel glue.
// Sequence: a load is accepted, then finished; a map is accepted, then walks k table
//   entries (k = matched track + 1, at most TRACKS), runs two divider passes with a reload
//   between them, and finishes once the response register is free. One beat at a time;
//   a new request is taken while a finished response still waits.
// Reset: synchronous, active high; clears the sequencer and response valid, not the table.
`timescale 1ns / 1ps
module zoned_disk_sector_mapper_core
   import zdsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   zdsm_req_if.sink          req_if,
   zdsm_rsp_if.source        rsp_if
);
   zdsm_cmd_type cmd;
   zdsm_sts_type sts;

   // The controller owns request ready and all sequencing; it never looks at
   // payload beyond the command bit.
   zdsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.cmd),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the table, the running base, the divider and the
   // response register that decouples the two channels.
   zdsm_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_track_index      (req_if.track_index),
      .req_sectors_in_track (req_if.sectors_in_track),
      .req_block_number     (req_if.block_number),
      .rsp_ready            (rsp_if.ready),
      .sts                  (sts),
      .rsp_valid            (rsp_if.valid),
      .rsp_track            (rsp_if.track),
      .rsp_sector           (rsp_if.sector),
      .rsp_beyond_end       (rsp_if.beyond_end)
   );

   // Hold an accepted beat's result until taken: response valid must stay up.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |=> rsp_if.valid)
      else $error("response beat dropped before it was taken");
endmodule

/* sv/zdsm_ram.sv */
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module zdsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/zdsm_ctrl.sv */
// Controller: sequences table walk, two divider passes and response hand-off.
`timescale 1ns / 1ps
module zdsm_ctrl
   import zdsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_cmd,
   output logic         req_ready,
   input  zdsm_sts_type sts,
   output zdsm_cmd_type cmd
);
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_DIV    = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [TRK_W-1:0]  idx_ff, idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              pass_ff, pass_in;
   logic              mod_ff, mod_in;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      step_in   = step_ff;
      pass_in   = pass_ff;
      mod_in    = 1'b0;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.idx   = idx_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_MAP) begin
                  cmd.start_map = 1'b1;
                  idx_in        = '0;
                  state_in      = S_WALK;
               end else begin
                  cmd.start_load = 1'b1;
                  state_in       = S_FINISH;
               end
            end
         end
         S_WALK: begin
            if (sts.hit || idx_ff == LAST_TRK) begin
               cmd.walk_stop = 1'b1;
               step_in       = '0;
               pass_in       = 1'b0;
               state_in      = S_DIV;
            end else begin
               cmd.walk_step = 1'b1;
               idx_in        = idx_ff + TRK_W'(1);
            end
         end
         S_DIV: begin
            if (mod_ff) begin
               // load the second dividend between passes
               cmd.div_next = 1'b1;
               pass_in      = 1'b1;
            end else begin
               cmd.div_step = 1'b1;
               if (step_ff == STEP_LAST) begin
                  step_in = '0;
                  if (pass_ff) begin
                     state_in = S_FINISH;
                  end else begin
                     mod_in = 1'b1;
                  end
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         step_ff  <= '0;
         pass_ff  <= 1'b0;
         mod_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         pass_ff  <= pass_in;
         mod_ff   <= mod_in;
      end
   end

   a_walk_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (idx_ff <= LAST_TRK))
      else $error("walk index ran past the last track");

   a_mod_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && !mod_ff && pass_ff && step_ff == STEP_LAST)
      |=> (state_ff == S_FINISH))
      else $error("second divider pass did not hand off to finish");

   a_single_pass_gap: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_stop) |=> (state_ff == S_DIV && !pass_ff && step_ff == '0))
      else $error("divider not started cleanly after walk");
endmodule

/* sv/zdsm_dp.sv */
// Datapath: sector table, cumulative walk, serial divider and response register.
`timescale 1ns / 1ps
module zdsm_dp
   import zdsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  zdsm_cmd_type         cmd,
   input  logic [TIX_W-1:0]     req_track_index,
   input  logic [CNT_W-1:0]     req_sectors_in_track,
   input  logic [BLK_W-1:0]     req_block_number,
   input  logic                 rsp_ready,
   output zdsm_sts_type         sts,
   output logic                 rsp_valid,
   output logic [TRK_OUT_W-1:0] rsp_track,
   output logic [SEC_W-1:0]     rsp_sector,
   output logic                 rsp_beyond_end
);
   logic [BLK_W-1:0]     blk_ff;
   logic [BLK_W-1:0]     base_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [TRK_W-1:0]     trk_ff;
   logic                 beyond_ff;
   logic [DQ_W-1:0]      dq_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [REM_W-1:0]     dvs_ff;
   logic                 rsp_valid_ff;
   logic [TRK_OUT_W-1:0] rsp_track_ff;
   logic [SEC_W-1:0]     rsp_sector_ff;
   logic                 rsp_beyond_ff;

   logic                 ram_we;
   logic [TRK_W-1:0]     ram_waddr;
   logic [CNT_W-1:0]     ram_wdata;
   logic [TRK_W-1:0]     ram_raddr;
   logic [CNT_W-1:0]     ram_rdata;

   logic [SUM_W-1:0]     sum;
   logic [BLK_W-1:0]     off;
   logic [CNT_W-1:0]     half_rd;
   logic [CNT_W-1:0]     half_cnt;
   logic [REM_W:0]       part;
   logic [REM_W+1:0]     diff;
   logic                 ge;

   // table write on a load beat inside the table; zero counts become one
   assign ram_we    = cmd.start_load && (32'(req_track_index) < 32'(TRACKS));
   assign ram_waddr = TRK_W'(req_track_index);
   assign ram_wdata = (req_sectors_in_track == '0) ? CNT_W'(1) : req_sectors_in_track;
   assign ram_raddr = cmd.walk_step ? (cmd.idx + TRK_W'(1)) : '0;

   zdsm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (TRACKS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign sum      = SUM_W'(base_ff) + SUM_W'(ram_rdata);
   assign sts.hit  = SUM_W'(blk_ff) < sum;
   assign off      = blk_ff - base_ff;
   assign half_rd  = CNT_W'((REM_W'(ram_rdata) + REM_W'(1)) >> 1);
   assign half_cnt = CNT_W'((REM_W'(cnt_ff) + REM_W'(1)) >> 1);

   // one restoring divide step
   assign part = {rem_ff, dq_ff[DQ_W-1]};
   assign diff = {1'b0, part} - (REM_W+2)'(dvs_ff);
   assign ge   = !diff[REM_W+1];

   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.start_map) begin
         blk_ff  <= req_block_number;
         base_ff <= '0;
      end
      if (cmd.walk_step) begin
         base_ff <= BLK_W'(sum);
      end
      if (cmd.start_load) begin
         cnt_ff    <= '0;
         trk_ff    <= '0;
         beyond_ff <= 1'b0;
      end
      if (cmd.walk_stop) begin
         cnt_ff    <= ram_rdata;
         trk_ff    <= cmd.idx;
         beyond_ff <= !sts.hit;
         dq_ff     <= DQ_W'(off);
         rem_ff    <= '0;
         dvs_ff    <= REM_W'(half_rd);
      end
      if (cmd.div_step) begin
         dq_ff  <= {dq_ff[DQ_W-2:0], ge};
         rem_ff <= ge ? diff[REM_W-1:0] : part[REM_W-1:0];
      end
      if (cmd.div_next) begin
         dq_ff  <= DQ_W'({off, 1'b0}) + dq_ff;
         rem_ff <= '0;
         dvs_ff <= {half_cnt, 1'b0};
      end
      if (cmd.finish) begin
         rsp_track_ff  <= TRK_OUT_W'(trk_ff);
         rsp_sector_ff <= (half_cnt == '0) ? '0 : SEC_W'(rem_ff);
         rsp_beyond_ff <= beyond_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_track      = rsp_track_ff;
   assign rsp_sector     = rsp_sector_ff;
   assign rsp_beyond_end = rsp_beyond_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten before it was taken");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item did not raise response valid");
endmodule

/* sim/zdsm_location_check.sv */
// Watches both channels, predicts each mapped location and compares it with the response.
`timescale 1ns / 1ps
module zdsm_location_check
   import zdsm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   zdsm_req_if  req_bus,
   zdsm_rsp_if  rsp_bus,
   output int   mismatches,
   output int   outstanding
);

   typedef struct packed {
      logic [TRK_OUT_W-1:0] track;
      logic [SEC_W-1:0]     sector;
      logic                 beyond_end;
   } location_type;

   // Shadow of the sector table; every entry is loaded before the first map.
   logic [CNT_W-1:0] sector_count [TRACKS];
   location_type     location_q [$];
   location_type     want;
   int               err_count;

   // Walk the cumulative counts, then apply the two-way skew to the offset.
   function automatic location_type locate_block(logic [BLK_W-1:0] blk);
      int           base;
      int           trk;
      int           n;
      int           off;
      int           half;
      int           sec;
      bit           beyond;
      location_type loc;
      base   = 0;
      trk    = TRACKS - 1;
      beyond = 1'b1;
      for (int t = 0; t < TRACKS; t++) begin
         n = int'(sector_count[t]);
         if (beyond) begin
            if (int'(blk) < base + n) begin
               trk    = t;
               beyond = 1'b0;
            end else begin
               base += n;
            end
         end
      end
      // past the end: step back over the last track so the offset is relative to it
      if (beyond)
         base -= int'(sector_count[TRACKS-1]);
      off  = int'(blk) - base;
      half = (int'(sector_count[trk]) + 1) >> 1;
      sec  = (half == 0) ? 0 : ((off << 1) + off / half) % (half << 1);
      loc.track      = TRK_OUT_W'(trk);
      loc.sector     = SEC_W'(sec);
      loc.beyond_end = beyond;
      return loc;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         location_q.delete();
         err_count = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.cmd == CMD_LOAD) begin
               // loads past the table are dropped, yet still answer with zeros
               if (req_bus.track_index < TRACKS)
                  sector_count[req_bus.track_index] =
                     (req_bus.sectors_in_track == '0) ? CNT_W'(1) : req_bus.sectors_in_track;
               location_q.push_back('0);
            end else begin
               location_q.push_back(locate_block(req_bus.block_number));
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (location_q.size() == 0) begin
               $error("response beat with no request waiting");
               err_count++;
            end else begin
               want = location_q.pop_front();
               if (rsp_bus.track !== want.track) begin
                  $error("track: expected %0d, actual %0d", want.track, rsp_bus.track);
                  err_count++;
               end
               if (rsp_bus.sector !== want.sector) begin
                  $error("sector: expected %0d, actual %0d", want.sector, rsp_bus.sector);
                  err_count++;
               end
               if (rsp_bus.beyond_end !== want.beyond_end) begin
                  $error("beyond_end: expected %0d, actual %0d",
                         want.beyond_end, rsp_bus.beyond_end);
                  err_count++;
               end
            end
         end
      end
      mismatches  <= err_count;
      outstanding <= location_q.size();
   end

endmodule

/* sim/testbench.sv */
// Top of the mapper testbench: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps
module testbench
   import zdsm_pkg::*;
   ;

   localparam int RANDOM_ITEMS = 1250;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 120;   // longer than the slowest map
   localparam int LONG_HOLD    = 300;

   logic clock;
   logic reset;

   zdsm_req_if req_bus ();
   zdsm_rsp_if rsp_bus ();

   int mismatches;
   int outstanding;
   int cycle_count = 0;
   bit hold_request = 1'b0;

   // Stored sector counts as the block sees them; used only to aim block numbers.
   int stored_count [TRACKS];

   zoned_disk_sector_mapper_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   zdsm_location_check u_location_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop: a hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Idle length for one beat. Runs of beats share a mood: busy (a randomly drawn
   // idle length) or calm (no idling at all), so both back-to-back and gappy traffic occur.
   function automatic int pick_wait(inout int run_left, inout bit calm);
      if (run_left == 0) begin
         run_left = $urandom_range(10, 60);
         calm     = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   // Sum of stored counts of all tracks below the given one.
   function automatic int blocks_before(int upto);
      int sum;
      sum = 0;
      for (int t = 0; t < upto; t++)
         sum += stored_count[t];
      return sum;
   endfunction

   // ------------------------------------------------------------------
   // Sender. Entered and left at a falling edge; holds the payload until the
   // beat is taken, then idles for a drawn number of cycles.
   // ------------------------------------------------------------------
   int  send_run  = 0;
   bit  send_calm = 1'b0;

   task automatic offer(input logic c, input logic [TIX_W-1:0] tix,
                        input logic [CNT_W-1:0] cnt, input logic [BLK_W-1:0] blk);
      int gap;
      req_bus.valid            <= 1'b1;
      req_bus.cmd              <= c;
      req_bus.track_index      <= tix;
      req_bus.sectors_in_track <= cnt;
      req_bus.block_number     <= blk;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
      if (c == CMD_LOAD && tix < TRACKS)
         stored_count[tix] = (cnt == 0) ? 1 : int'(cnt);
      gap = pick_wait(send_run, send_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Unused payload fields carry random bits so every input bit toggles.
   task automatic load_track(input int tix, input int cnt);
      offer(CMD_LOAD, TIX_W'(tix), CNT_W'(cnt), BLK_W'($urandom));
   endtask

   task automatic map_block(input int blk);
      offer(CMD_MAP, TIX_W'($urandom), CNT_W'($urandom), BLK_W'(blk));
   endtask

   // Stop offering until every issued beat has been answered.
   task automatic drain_responses;
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Receiver. Draws a stall after each response beat; once asked, holds
   // ready low for a long stretch so the block backs up into its input.
   // ------------------------------------------------------------------
   initial begin
      int  stall;
      int  recv_run;
      bit  recv_calm;
      bit  took;
      bit  long_hold_done;
      stall          = 0;
      recv_run       = 0;
      recv_calm      = 1'b0;
      long_hold_done = 1'b0;
      rsp_bus.ready  = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         @(posedge clock);
         took = rsp_bus.valid && rsp_bus.ready;
         @(negedge clock);
         if (took)
            stall = pick_wait(recv_run, recv_calm);
         if (hold_request && !long_hold_done) begin
            stall          = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and verdict.
   // ------------------------------------------------------------------
   initial begin
      int total;
      int kind;
      int tix;
      int cnt;
      int blk;
      req_bus.valid            = 1'b0;
      req_bus.cmd              = CMD_LOAD;
      req_bus.track_index      = '0;
      req_bus.sectors_in_track = '0;
      req_bus.block_number     = '0;
      reset                    = 1'b1;
      for (int t = 0; t < TRACKS; t++)
         stored_count[t] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill the whole table before any map: track 0 gets a zero count (held
      // as one), track 1 a one, the last track the largest count.
      for (int t = 0; t < TRACKS; t++) begin
         if (t == 0)
            cnt = 0;
         else if (t == 1)
            cnt = 1;
         else if (t == TRACKS - 1)
            cnt = 31;
         else
            cnt = $urandom_range(0, 31);
         load_track(t, cnt);
      end

      // Directed: dropped loads, table edges, track boundaries, the end of the
      // disk and blocks far past it.
      load_track(127, 31);
      load_track(TRACKS, 17);
      total = blocks_before(TRACKS);
      map_block(0);
      map_block(1);
      map_block(blocks_before(40) - 1);
      map_block(blocks_before(40));
      map_block(total - 31);
      map_block(total - 16);
      map_block(total - 1);
      map_block(total);
      map_block(4095);
      // Shrink the last track to one sector: big offsets past the end, half = 1.
      load_track(TRACKS - 1, 0);
      map_block(blocks_before(TRACKS) + 100);
      load_track(TRACKS - 1, 2);
      map_block(4095);
      load_track(TRACKS - 1, 31);
      // Widest first track: offsets of a 31-sector track at its top and either side of its half.
      load_track(0, 31);
      map_block(30);
      map_block(15);
      map_block(16);

      // Let everything settle before the random part.
      drain_responses();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 400)
            drain_responses();
         if (i == 700)
            hold_request = 1'b1;
         kind = $urandom_range(0, 99);
         if (kind < 22) begin
            tix = ($urandom_range(0, 9) == 0) ? $urandom_range(TRACKS, 127)
                                              : $urandom_range(0, TRACKS - 1);
            cnt = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 31);
            load_track(tix, cnt);
         end else begin
            total = blocks_before(TRACKS);
            kind  = $urandom_range(0, 9);
            // Mostly blocks on the disk; some at its end; some anywhere.
            if (kind < 7)
               blk = $urandom_range(0, total - 1);
            else if (kind < 8)
               blk = $urandom_range(total - 2, total + 1);
            else
               blk = $urandom_range(0, 4095);
            map_block(blk);
         end
      end

      req_bus.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
sv/zdsm_pkg.sv
sv/zdsm_req_if.sv
sv/zdsm_rsp_if.sv
sv/zdsm_ram.sv
sv/zdsm_ctrl.sv
sv/zdsm_dp.sv
sv/zoned_disk_sector_mapper_core.sv
sim/zdsm_location_check.sv
sim/testbench.sv
